// ===== rtl/core/script_source_lexer_top_defines.svh =====
// Assertion helpers shared by the lexer queue and serialiser modules.
// Both expect clk and rst_n in the scope of the module that uses them.
`ifndef SCRIPT_SOURCE_LEXER_TOP_DEFINES_SVH
`define SCRIPT_SOURCE_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ssl_pkg.sv =====
package ssl_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_OP    = 4'd1,
    MODE_SLASH = 4'd2,
    MODE_LINE  = 4'd3,
    MODE_BLOCK = 4'd4,
    MODE_BSTAR = 4'd5,
    MODE_STR   = 4'd6,
    MODE_ESC   = 4'd7,
    MODE_NUM   = 4'd8,
    MODE_WORD  = 4'd9
  } mode_t;

  localparam logic [5:0] KIND_LBRACKET = 6'd0;
  localparam logic [5:0] KIND_RBRACKET = 6'd1;
  localparam logic [5:0] KIND_LBRACE   = 6'd2;
  localparam logic [5:0] KIND_RBRACE   = 6'd3;
  localparam logic [5:0] KIND_LPAREN   = 6'd4;
  localparam logic [5:0] KIND_RPAREN   = 6'd5;
  localparam logic [5:0] KIND_DOT      = 6'd6;
  localparam logic [5:0] KIND_COLON    = 6'd7;
  localparam logic [5:0] KIND_SEMI     = 6'd8;
  localparam logic [5:0] KIND_PLUS     = 6'd9;
  localparam logic [5:0] KIND_MINUS    = 6'd11;
  localparam logic [5:0] KIND_ASSIGN   = 6'd13;
  localparam logic [5:0] KIND_SLASH    = 6'd15;
  localparam logic [5:0] KIND_STAR     = 6'd16;
  localparam logic [5:0] KIND_LESS     = 6'd17;
  localparam logic [5:0] KIND_GREATER  = 6'd19;
  localparam logic [5:0] KIND_BANG     = 6'd21;
  localparam logic [5:0] KIND_STRING   = 6'd23;
  localparam logic [5:0] KIND_INTEGER  = 6'd24;
  localparam logic [5:0] KIND_FLOAT    = 6'd25;
  localparam logic [5:0] KIND_KW_INT   = 6'd26;
  localparam logic [5:0] KIND_KW_STR   = 6'd27;
  localparam logic [5:0] KIND_KW_BOOL  = 6'd28;
  localparam logic [5:0] KIND_KW_VAR   = 6'd29;
  localparam logic [5:0] KIND_KW_TRUE  = 6'd30;
  localparam logic [5:0] KIND_KW_FALSE = 6'd31;
  localparam logic [5:0] KIND_SYMBOL   = 6'd32;
  localparam logic [5:0] KIND_EOF      = 6'd33;
  localparam logic [5:0] KIND_UNTERM   = 6'd34;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BANG      = 8'h21;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_LESS      = 8'h3C;
  localparam logic [7:0] CH_EQUAL     = 8'h3D;
  localparam logic [7:0] CH_GREATER   = 8'h3E;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  // Keyword text, first character in the lowest byte.
  localparam logic [47:0] KW_INT   = 48'h0000_00746e69;
  localparam logic [47:0] KW_STR   = 48'h676e_69727473;
  localparam logic [47:0] KW_BOOL  = 48'h0000_6c6f6f62;
  localparam logic [47:0] KW_VAR   = 48'h0000_00726176;
  localparam logic [47:0] KW_TRUE  = 48'h0000_65757274;
  localparam logic [47:0] KW_FALSE = 48'h0065_736c6166;

  localparam int QPTR_W = 2;
  localparam int QDEPTH = 1 << QPTR_W;

  typedef struct packed {
    logic       is_text;
    logic [7:0] text_byte;
    logic [5:0] token_kind;
  } rec_t;

  typedef struct packed {
    logic [2:0]      count;
    rec_t [3:0]      recs;
  } bundle_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t [1:0] recs;
    mode_t      mode;
    logic [7:0] pend;
  } start_t;

  function automatic rec_t text_rec(input logic [7:0] b);
    rec_t r;
    r.is_text    = 1'b1;
    r.text_byte  = b;
    r.token_kind = 6'd0;
    return r;
  endfunction

  function automatic rec_t end_rec(input logic [5:0] k);
    rec_t r;
    r.is_text    = 1'b0;
    r.text_byte  = 8'h00;
    r.token_kind = k;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] p);
    logic [5:0] k;
    case (p)
      CH_PLUS:    k = KIND_PLUS;
      CH_MINUS:   k = KIND_MINUS;
      CH_EQUAL:   k = KIND_ASSIGN;
      CH_LESS:    k = KIND_LESS;
      CH_GREATER: k = KIND_GREATER;
      default:    k = KIND_BANG;
    endcase
    return k;
  endfunction

  // Bytes past the word length are always zero, so whole-word compares suffice.
  function automatic logic [5:0] word_kind(input logic [47:0] p, input logic [2:0] n);
    logic [5:0] k;
    k = KIND_SYMBOL;
    if (n == 3'd3 && p == KW_INT) k = KIND_KW_INT;
    if (n == 3'd6 && p == KW_STR) k = KIND_KW_STR;
    if (n == 3'd4 && p == KW_BOOL) k = KIND_KW_BOOL;
    if (n == 3'd3 && p == KW_VAR) k = KIND_KW_VAR;
    if (n == 3'd4 && p == KW_TRUE) k = KIND_KW_TRUE;
    if (n == 3'd5 && p == KW_FALSE) k = KIND_KW_FALSE;
    return k;
  endfunction

  // What a byte does when it arrives between tokens.
  function automatic start_t start_token(input logic [7:0] b);
    start_t     s;
    logic       punct;
    logic [5:0] pk;
    s       = '0;
    s.mode  = MODE_IDLE;
    punct   = 1'b1;
    pk      = KIND_LBRACKET;
    case (b)
      CH_LBRACKET: pk = KIND_LBRACKET;
      CH_RBRACKET: pk = KIND_RBRACKET;
      CH_LBRACE:   pk = KIND_LBRACE;
      CH_RBRACE:   pk = KIND_RBRACE;
      CH_LPAREN:   pk = KIND_LPAREN;
      CH_RPAREN:   pk = KIND_RPAREN;
      CH_DOT:      pk = KIND_DOT;
      CH_COLON:    pk = KIND_COLON;
      CH_SEMI:     pk = KIND_SEMI;
      CH_STAR:     pk = KIND_STAR;
      default:     punct = 1'b0;
    endcase
    if (punct) begin
      s.count   = 2'd2;
      s.recs[0] = text_rec(b);
      s.recs[1] = end_rec(pk);
    end else if (b == CH_PLUS || b == CH_MINUS || b == CH_EQUAL || b == CH_LESS ||
                 b == CH_GREATER || b == CH_BANG) begin
      s.count   = 2'd1;
      s.recs[0] = text_rec(b);
      s.mode    = MODE_OP;
      s.pend    = b;
    end else if (b == CH_SLASH) begin
      s.mode = MODE_SLASH;
    end else if (b == CH_QUOTE) begin
      s.mode = MODE_STR;
    end else if (is_digit(b)) begin
      s.count   = 2'd1;
      s.recs[0] = text_rec(b);
      s.mode    = MODE_NUM;
    end else if (is_alpha(b) || b == CH_UNDERSCORE) begin
      s.count   = 2'd1;
      s.recs[0] = text_rec(b);
      s.mode    = MODE_WORD;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/script_source_lexer_top.sv =====
// Streaming lexer: source bytes in, token records out.
// Input channel: in_tdata[7:0] carries one source byte, in_tlast marks end of
// input (the byte is then ignored, the open token is closed and an end-of-file
// record follows). Output channel: each record is either one token text byte
// (out_tuser high) or a token end record carrying the kind (out_tuser low);
// out_tlast marks the final record caused by one input transfer.
// One input transfer is taken per cycle while the four-entry bundle queue
// between the lexing front end and the record serialiser has room. Each input
// causes zero to four records, and the serialiser sends one record per cycle
// while the receiver is ready, so sustained input rate is one byte per cycle
// when each byte causes at most one record; longer bursts drain at one record
// per cycle from the queue. With the queue empty and the output register free,
// the first record of an input goes into the queue at its transfer and then
// into the output register, which drives out_tvalid. When the receiver stalls,
// the output register holds its record, the queue fills and then in_tready
// falls; nothing is dropped.
// Reset (rst_n low, synchronous) returns the lexer to idle between tokens,
// empties the queue and clears out_tvalid.
module script_source_lexer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] text_byte, [13:8] token_kind, rest zero
  output logic        out_tuser,  // is_text
  output logic        out_tlast   // last_of_run
);
  import ssl_pkg::*;

  logic    accept;
  bundle_t bundle;
  bundle_t head;
  logic    head_valid;
  logic    full;
  logic    pop;
  rec_t    rec;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  ssl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_end  (in_tlast),
    .bundle  (bundle)
  );

  ssl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && (bundle.count != 3'd0)),
    .push_data  (bundle),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  ssl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_rec    (rec),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, rec.token_kind, rec.text_byte};
  assign out_tuser = rec.is_text;

endmodule

// ===== rtl/core/ssl_front.sv =====
module ssl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             in_end,
  output ssl_pkg::bundle_t bundle
);
  import ssl_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        point_r, point_nxt;
  logic [47:0] prefix_r, prefix_nxt;
  logic [2:0]  len_r, len_nxt;

  logic [1:0]  pre_n;
  rec_t [1:0]  pre;
  logic [1:0]  tail_n;
  rec_t [1:0]  tail;
  logic        use_start;
  logic        go_idle;
  logic        word_add;
  logic [7:0]  second;
  start_t      st;

  always_comb begin
    st         = start_token(in_byte);
    pre_n      = 2'd0;
    pre        = '0;
    use_start  = 1'b0;
    go_idle    = 1'b0;
    word_add   = 1'b0;
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    point_nxt  = point_r;
    prefix_nxt = prefix_r;
    len_nxt    = len_r;
    second     = (pend_r == CH_PLUS || pend_r == CH_MINUS || pend_r == CH_EQUAL) ?
                 pend_r : CH_EQUAL;

    if (in_end) begin
      go_idle = 1'b1;
      case (mode_r)
        MODE_OP: begin
          pre_n  = 2'd1;
          pre[0] = end_rec(single_kind(pend_r));
        end
        MODE_SLASH: begin
          pre_n  = 2'd2;
          pre[0] = text_rec(CH_SLASH);
          pre[1] = end_rec(KIND_SLASH);
        end
        MODE_STR, MODE_ESC: begin
          pre_n  = 2'd1;
          pre[0] = end_rec(KIND_UNTERM);
        end
        MODE_NUM: begin
          pre_n  = 2'd1;
          pre[0] = end_rec(point_r ? KIND_FLOAT : KIND_INTEGER);
        end
        MODE_WORD: begin
          pre_n  = 2'd1;
          pre[0] = end_rec(word_kind(prefix_r, len_r));
        end
        default: ;
      endcase
    end else begin
      case (mode_r)
        MODE_OP: begin
          go_idle = 1'b1;
          if (in_byte == second) begin
            pre_n  = 2'd2;
            pre[0] = text_rec(in_byte);
            pre[1] = end_rec(single_kind(pend_r) + 6'd1);
          end else begin
            pre_n     = 2'd1;
            pre[0]    = end_rec(single_kind(pend_r));
            use_start = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (in_byte == CH_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (in_byte == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end else begin
            pre_n     = 2'd2;
            pre[0]    = text_rec(CH_SLASH);
            pre[1]    = end_rec(KIND_SLASH);
            go_idle   = 1'b1;
            use_start = 1'b1;
          end
        end
        MODE_LINE: begin
          if (in_byte == CH_NEWLINE) go_idle = 1'b1;
        end
        MODE_BLOCK: begin
          if (in_byte == CH_STAR) mode_nxt = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (in_byte == CH_SLASH) go_idle = 1'b1;
          else if (in_byte != CH_STAR) mode_nxt = MODE_BLOCK;
        end
        MODE_STR: begin
          if (in_byte == CH_QUOTE) begin
            pre_n   = 2'd1;
            pre[0]  = end_rec(KIND_STRING);
            go_idle = 1'b1;
          end else if (in_byte == CH_BACKSLASH) begin
            mode_nxt = MODE_ESC;
          end else if (in_byte == CH_NEWLINE) begin
            pre_n   = 2'd1;
            pre[0]  = end_rec(KIND_UNTERM);
            go_idle = 1'b1;
          end else begin
            pre_n  = 2'd1;
            pre[0] = text_rec(in_byte);
          end
        end
        MODE_ESC: begin
          pre_n = 2'd1;
          if (in_byte == CH_NEWLINE) begin
            pre[0]  = end_rec(KIND_UNTERM);
            go_idle = 1'b1;
          end else begin
            pre[0]   = text_rec(in_byte);
            mode_nxt = MODE_STR;
          end
        end
        MODE_NUM: begin
          pre_n = 2'd1;
          if (is_digit(in_byte)) begin
            pre[0] = text_rec(in_byte);
          end else if (in_byte == CH_DOT && !point_r) begin
            pre[0]    = text_rec(in_byte);
            point_nxt = 1'b1;
          end else begin
            pre[0]    = end_rec(point_r ? KIND_FLOAT : KIND_INTEGER);
            go_idle   = 1'b1;
            use_start = 1'b1;
          end
        end
        MODE_WORD: begin
          pre_n = 2'd1;
          if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == CH_UNDERSCORE) begin
            pre[0]   = text_rec(in_byte);
            word_add = 1'b1;
          end else begin
            pre[0]    = end_rec(word_kind(prefix_r, len_r));
            go_idle   = 1'b1;
            use_start = 1'b1;
          end
        end
        default: begin
          go_idle   = 1'b1;
          use_start = 1'b1;
        end
      endcase
    end

    if (word_add) begin
      for (int i = 0; i < 6; i++) begin
        if (len_r == 3'(i)) prefix_nxt[8*i +: 8] = in_byte;
      end
      if (len_r != 3'd7) len_nxt = len_r + 3'd1;
    end

    if (go_idle) begin
      mode_nxt   = MODE_IDLE;
      pend_nxt   = 8'h00;
      point_nxt  = 1'b0;
      prefix_nxt = '0;
      len_nxt    = 3'd0;
    end

    // The start of a new token overrides the idle state set above.
    tail_n = 2'd0;
    tail   = '0;
    if (in_end) begin
      tail_n  = 2'd1;
      tail[0] = end_rec(KIND_EOF);
    end else if (use_start) begin
      tail_n   = st.count;
      tail     = st.recs;
      mode_nxt = st.mode;
      pend_nxt = st.pend;
      if (st.mode == MODE_WORD) begin
        prefix_nxt = {40'd0, in_byte};
        len_nxt    = 3'd1;
      end
    end

    bundle.count = {1'b0, pre_n} + {1'b0, tail_n};
    bundle.recs  = '0;
    case (pre_n)
      2'd0: begin
        bundle.recs[0] = tail[0];
        bundle.recs[1] = tail[1];
      end
      2'd1: begin
        bundle.recs[0] = pre[0];
        bundle.recs[1] = tail[0];
        bundle.recs[2] = tail[1];
      end
      default: begin
        bundle.recs[0] = pre[0];
        bundle.recs[1] = pre[1];
        bundle.recs[2] = tail[0];
        bundle.recs[3] = tail[1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pend_r   <= 8'h00;
      point_r  <= 1'b0;
      prefix_r <= '0;
      len_r    <= 3'd0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      point_r  <= point_nxt;
      prefix_r <= prefix_nxt;
      len_r    <= len_nxt;
    end
  end

endmodule

// ===== rtl/core/ssl_queue.sv =====
`include "script_source_lexer_top_defines.svh"

module ssl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ssl_pkg::bundle_t push_data,
  input  logic             pop,
  output ssl_pkg::bundle_t head,
  output logic             head_valid,
  output logic             full
);
  import ssl_pkg::*;

  bundle_t             q_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r;
  logic [QPTR_W-1:0]   rd_r;
  logic [QPTR_W:0]     count_r;

  assign head       = q_r[rd_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == (QPTR_W+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  `SSL_ASSERT_IMP(a_no_push_full, push, !full, "bundle written into a full queue")
  `SSL_ASSERT_IMP(a_no_pop_empty, pop, head_valid, "bundle taken from an empty queue")
  `SSL_ASSERT_NXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1,
                  "queue fill level did not rise on a lone write")

endmodule

// ===== rtl/core/ssl_back.sv =====
`include "script_source_lexer_top_defines.svh"

module ssl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ssl_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_valid,
  output ssl_pkg::rec_t    out_rec,
  output logic             out_last
);
  import ssl_pkg::*;

  logic [1:0] idx_r;
  logic       valid_r;
  rec_t       rec_r;
  logic       last_r;
  logic       load;
  logic       at_last;

  assign load    = head_valid && (!valid_r || out_ready);
  assign at_last = ({1'b0, idx_r} + 3'd1) == head.count;
  assign pop     = load && at_last;

  assign out_valid = valid_r;
  assign out_rec   = rec_r;
  assign out_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= at_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r  <= head.recs[idx_r];
      last_r <= at_last;
    end
  end

  `SSL_ASSERT_IMP(a_mid_bundle_head, idx_r != 2'd0, head_valid,
                  "bundle left the queue before all its records were sent")
  `SSL_ASSERT_IMP(a_idx_in_range, head_valid, {1'b0, idx_r} < head.count,
                  "record index beyond the bundle's record count")
  `SSL_ASSERT_NXT(a_hold_on_stall, valid_r && !out_ready,
                  valid_r && rec_r == $past(rec_r) && last_r == $past(last_r),
                  "output record changed while the receiver stalled")

endmodule

// ===== sim/tb.sv =====
module tb;
  import ssl_pkg::*;

  typedef struct packed {
    logic       is_text;
    logic [7:0] text_byte;
    logic [5:0] kind;
    logic       last;
  } lex_rec_t;

  class token_scoreboard;
    mode_t       mode;
    logic [7:0]  pend_op;
    logic        point_seen;
    logic [47:0] prefix;
    logic [2:0]  wlen;
    lex_rec_t    expected_recs[$];
    lex_rec_t    burst[$];
    int          errors;

    function new();
      clear_token();
      errors = 0;
    endfunction

    function void clear_token();
      mode       = MODE_IDLE;
      pend_op    = 8'h00;
      point_seen = 1'b0;
      prefix     = 48'h0;
      wlen       = 3'd0;
    endfunction

    function void emit(logic t, logic [7:0] b, logic [5:0] k);
      lex_rec_t r;
      r.is_text   = t;
      r.text_byte = b;
      r.kind      = k;
      r.last      = 1'b0;
      if (burst.size() < 4) burst = {burst, r};
    endfunction

    function void emit_text(logic [7:0] b);
      emit(1'b1, b, 6'd0);
    endfunction

    function void emit_end(logic [5:0] k);
      emit(1'b0, 8'h00, k);
    endfunction

    function logic digit_char(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function logic alpha_char(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function logic [5:0] op_kind(logic [7:0] p);
      case (p)
        CH_PLUS:    return KIND_PLUS;
        CH_MINUS:   return KIND_MINUS;
        CH_EQUAL:   return KIND_ASSIGN;
        CH_LESS:    return KIND_LESS;
        CH_GREATER: return KIND_GREATER;
        default:    return KIND_BANG;
      endcase
    endfunction

    function logic [5:0] ident_kind();
      if (wlen == 3'd3 && prefix == KW_INT) return KIND_KW_INT;
      if (wlen == 3'd6 && prefix == KW_STR) return KIND_KW_STR;
      if (wlen == 3'd4 && prefix == KW_BOOL) return KIND_KW_BOOL;
      if (wlen == 3'd3 && prefix == KW_VAR) return KIND_KW_VAR;
      if (wlen == 3'd4 && prefix == KW_TRUE) return KIND_KW_TRUE;
      if (wlen == 3'd5 && prefix == KW_FALSE) return KIND_KW_FALSE;
      return KIND_SYMBOL;
    endfunction

    function void add_char(logic [7:0] b);
      if (wlen < 3'd6) prefix[8*wlen +: 8] = b;
      if (wlen < 3'd7) wlen = wlen + 3'd1;
    endfunction

    function logic [5:0] number_kind();
      return point_seen ? KIND_FLOAT : KIND_INTEGER;
    endfunction

    // A byte seen between tokens.
    function void open_token(logic [7:0] b);
      case (b)
        CH_LBRACKET: begin emit_text(b); emit_end(KIND_LBRACKET); end
        CH_RBRACKET: begin emit_text(b); emit_end(KIND_RBRACKET); end
        CH_LBRACE:   begin emit_text(b); emit_end(KIND_LBRACE); end
        CH_RBRACE:   begin emit_text(b); emit_end(KIND_RBRACE); end
        CH_LPAREN:   begin emit_text(b); emit_end(KIND_LPAREN); end
        CH_RPAREN:   begin emit_text(b); emit_end(KIND_RPAREN); end
        CH_DOT:      begin emit_text(b); emit_end(KIND_DOT); end
        CH_COLON:    begin emit_text(b); emit_end(KIND_COLON); end
        CH_SEMI:     begin emit_text(b); emit_end(KIND_SEMI); end
        CH_STAR:     begin emit_text(b); emit_end(KIND_STAR); end
        CH_PLUS, CH_MINUS, CH_EQUAL, CH_LESS, CH_GREATER, CH_BANG: begin
          emit_text(b);
          mode    = MODE_OP;
          pend_op = b;
        end
        CH_SLASH: mode = MODE_SLASH;
        CH_QUOTE: mode = MODE_STR;
        default: begin
          if (digit_char(b)) begin
            emit_text(b);
            mode       = MODE_NUM;
            point_seen = 1'b0;
          end else if (alpha_char(b) || b == CH_UNDERSCORE) begin
            emit_text(b);
            mode   = MODE_WORD;
            prefix = 48'h0;
            wlen   = 3'd0;
            add_char(b);
          end
        end
      endcase
    endfunction

    function void take(logic [7:0] b);
      logic [7:0] second;
      case (mode)
        MODE_OP: begin
          second = (pend_op == CH_PLUS || pend_op == CH_MINUS || pend_op == CH_EQUAL) ?
                   pend_op : CH_EQUAL;
          if (b == second) begin
            emit_text(b);
            emit_end(op_kind(pend_op) + 6'd1);
            clear_token();
          end else begin
            emit_end(op_kind(pend_op));
            clear_token();
            open_token(b);
          end
        end
        MODE_SLASH: begin
          if (b == CH_SLASH) mode = MODE_LINE;
          else if (b == CH_STAR) mode = MODE_BLOCK;
          else begin
            emit_text(CH_SLASH);
            emit_end(KIND_SLASH);
            clear_token();
            open_token(b);
          end
        end
        MODE_LINE: if (b == CH_NEWLINE) clear_token();
        MODE_BLOCK: if (b == CH_STAR) mode = MODE_BSTAR;
        MODE_BSTAR: begin
          if (b == CH_SLASH) clear_token();
          else if (b != CH_STAR) mode = MODE_BLOCK;
        end
        MODE_STR: begin
          if (b == CH_QUOTE) begin
            emit_end(KIND_STRING);
            clear_token();
          end else if (b == CH_BACKSLASH) mode = MODE_ESC;
          else if (b == CH_NEWLINE) begin
            emit_end(KIND_UNTERM);
            clear_token();
          end else emit_text(b);
        end
        MODE_ESC: begin
          if (b == CH_NEWLINE) begin
            emit_end(KIND_UNTERM);
            clear_token();
          end else begin
            emit_text(b);
            mode = MODE_STR;
          end
        end
        MODE_NUM: begin
          if (digit_char(b)) emit_text(b);
          else if (b == CH_DOT && !point_seen) begin
            emit_text(b);
            point_seen = 1'b1;
          end else begin
            emit_end(number_kind());
            clear_token();
            open_token(b);
          end
        end
        MODE_WORD: begin
          if (alpha_char(b) || digit_char(b) || b == CH_UNDERSCORE) begin
            emit_text(b);
            add_char(b);
          end else begin
            emit_end(ident_kind());
            clear_token();
            open_token(b);
          end
        end
        default: begin
          clear_token();
          open_token(b);
        end
      endcase
    endfunction

    function void close_input();
      case (mode)
        MODE_OP: emit_end(op_kind(pend_op));
        MODE_SLASH: begin
          emit_text(CH_SLASH);
          emit_end(KIND_SLASH);
        end
        MODE_STR, MODE_ESC: emit_end(KIND_UNTERM);
        MODE_NUM: emit_end(number_kind());
        MODE_WORD: emit_end(ident_kind());
        default: ;
      endcase
      emit_end(KIND_EOF);
      clear_token();
    endfunction

    // Notes one accepted source transfer; returns the number of records it causes.
    function int note_source(logic [7:0] b, logic eoi);
      burst.delete();
      if (eoi) close_input();
      else take(b);
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expected_recs = {expected_recs, burst[i]};
      return burst.size();
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_record(logic t, logic [15:0] d, logic l);
      lex_rec_t e;
      if (expected_recs.size() == 0) begin
        report($sformatf("record with nothing expected: text=%0b data=%h last=%0b", t, d, l));
        return;
      end
      e = expected_recs.pop_front();
      if (t !== e.is_text || d[7:0] !== e.text_byte || d[13:8] !== e.kind ||
          d[15:14] !== 2'b00 || l !== e.last)
        report($sformatf("got text=%0b byte=%h kind=%0d pad=%b last=%0b, want %0b %h %0d 00 %0b",
                         t, d[7:0], d[13:8], d[15:14], l,
                         e.is_text, e.text_byte, e.kind, e.last));
    endtask
  endclass

  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  token_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int cycles = 0;
  int sent_items;

  string kw_list[6] = '{"int", "string", "bool", "var", "true", "false"};
  string op_list[12] = '{"+", "++", "-", "--", "=", "==", "<", "<=", ">", ">=", "!", "!="};
  string punct_chars = "[]{}().:;*";
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string text_chars = "abc XYZ 019 _;+-=*/[]{}().:<>!#$%";

  script_source_lexer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_record(out_tuser, out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Valid is left high after a transfer, so back-to-back items need no second
  // assignment in the same step; it only falls when the sender idles.
  task send_byte(logic [7:0] b, logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eoi;
    do @(posedge clk); while (!in_tready);
    void'(sb.note_source(b, eoi));
    sent_items++;
    @(negedge clk);
  endtask

  task send_str(string s);
    foreach (s[i]) send_byte(s[i], 1'b0);
  endtask

  task send_word_char(logic lead);
    if (lead) send_byte(word_chars[$urandom_range(52)], 1'b0);
    else send_byte(word_chars[$urandom_range(word_chars.len() - 1)], 1'b0);
  endtask

  // One token-shaped fragment with random content, now and then malformed.
  task send_fragment();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_str(kw_list[$urandom_range(5)]);
      if ($urandom_range(4) == 0) send_word_char(1'b0);
    end else if (pick < 30) begin
      n = $urandom_range(1, 9);
      send_word_char(1'b1);
      repeat (n - 1) send_word_char(1'b0);
    end else if (pick < 43) begin
      repeat ($urandom_range(1, 4)) send_byte(8'("0" + $urandom_range(9)), 1'b0);
      if ($urandom_range(1)) begin
        send_byte(CH_DOT, 1'b0);
        repeat ($urandom_range(0, 3)) send_byte(8'("0" + $urandom_range(9)), 1'b0);
        if ($urandom_range(5) == 0) send_byte(CH_DOT, 1'b0);
      end
    end else if (pick < 56) begin
      send_str(op_list[$urandom_range(11)]);
    end else if (pick < 66) begin
      send_byte(punct_chars[$urandom_range(punct_chars.len() - 1)], 1'b0);
    end else if (pick < 76) begin
      send_byte(CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 6)) begin
        n = $urandom_range(9);
        if (n == 0) send_byte(8'($urandom_range(255)), 1'b0);
        else if (n == 1) begin
          send_byte(CH_BACKSLASH, 1'b0);
          send_byte(8'($urandom_range(255)), 1'b0);
        end else send_byte(text_chars[$urandom_range(text_chars.len() - 1)], 1'b0);
      end
      n = $urandom_range(19);
      if (n == 0) send_byte(CH_NEWLINE, 1'b0);
      else if (n > 1) send_byte(CH_QUOTE, 1'b0);
    end else if (pick < 84) begin
      send_byte(CH_SLASH, 1'b0);
      if ($urandom_range(1)) begin
        send_byte(CH_SLASH, 1'b0);
        repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
      end else begin
        send_byte(CH_STAR, 1'b0);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(2) == 0) send_byte(CH_STAR, 1'b0);
          else send_byte(8'($urandom_range(255)), 1'b0);
        end
        send_str("*/");
      end
    end else if (pick < 92) begin
      send_byte(8'($urandom_range(255)), 1'b0);
    end else if (pick < 96) begin
      send_byte(CH_SLASH, 1'b0);
    end else begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end
    n = $urandom_range(9);
    if (n < 5) send_byte(" ", 1'b0);
    else if (n == 5) send_byte(CH_NEWLINE, 1'b0);
    else if (n == 6) send_byte(8'h09, 1'b0);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'h00;
    in_tlast      = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    sent_items    = 0;
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero and top bytes between tokens, a number with a second point, an
    // escaped letter, a newline inside a string, both comment forms, end of
    // input inside a string, a lone slash at the end and end inside a comment.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_str("1.2.\"\\q\"\"\n//x\n/**/\"");
    send_byte(8'hA5, 1'b1);
    send_byte(CH_SLASH, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_str("/*");
    send_byte(8'h00, 1'b1);

    while (sent_items < 150) begin
      case (sent_items * 4 / 150)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      send_fragment();
    end
    send_byte(8'($urandom_range(255)), 1'b1);
    in_tvalid <= 1'b0;

    while (sb.expected_recs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ssl_pkg.sv
rtl/core/ssl_front.sv
rtl/core/ssl_queue.sv
rtl/core/ssl_back.sv
rtl/core/script_source_lexer_top.sv
sim/tb.sv
